>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on the rising edge of clock, off while reset is high.
`define QTD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that also hold while reset is high.
`define QTD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> src/qtd_pkg.sv
`default_nettype none

package qtd_pkg;

   localparam int HIDDEN_UNITS_DEF = 16;
   localparam int STATE_COUNT_DEF  = 8;

   localparam int PROD_W     = 66;
   localparam int RND_W      = 50;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_DATA_W = 17;

   localparam logic [2:0] ACT_INFER = 3'd0;
   localparam logic [2:0] ACT_TRAIN = 3'd1;
   localparam logic [2:0] ACT_SYNC  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [1:0] KIND_HW = 2'd0;
   localparam logic [1:0] KIND_HB = 2'd1;
   localparam logic [1:0] KIND_OW = 2'd2;
   localparam logic [1:0] KIND_OB = 2'd3;

   localparam logic CSR_LR   = 1'b0;
   localparam logic CSR_DISC = 1'b1;

   localparam logic [15:0] LR_RESET   = 16'd328;
   localparam logic [16:0] DISC_RESET = 17'd58982;

   typedef logic signed [31:0] word_type;

   function automatic word_type sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return x[31:0];
      end
   endfunction

   // round to Q16, halves toward plus infinity
   function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(32768);
      return t[PROD_W-1:16];
   endfunction

endpackage

`default_nettype wire

>>> src/qtd_ram.sv
`default_nettype none

module qtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> src/qnet_td_trainer.sv
// Channel  Dir  Ports                     Contents
// req      in   req_tvalid/tready/tdata   one command transaction (tuser = action)
// rsp      out  rsp_tvalid/tready/tdata   one result transaction per command
// csr      in   csr_valid/ready/index     learning_rate (0), discount (1)
//
// Weights of each network live in one RAM, read one word a cycle through one
// shared multiplier. Let H = HIDDEN_UNITS, D = H*STATE_COUNT + 3*H + 2.
// Each RAM holds D words. After reset a clearing pass zeroes both RAMs; no
// command is taken meanwhile. A held result does not stop the next command
// from entering; the engine waits at its end until the result register is free.
`default_nettype none
`include "assert_macros.svh"

module qnet_td_trainer
   import qtd_pkg::*;
#(
   parameter int HIDDEN_UNITS = HIDDEN_UNITS_DEF,
   parameter int STATE_COUNT  = STATE_COUNT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // state_index, chosen_move, reward, next_state, episode_end, weight_kind,
   // weight_row, weight_col, weight_value, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  wire logic [2:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // q_first, q_second, greedy_move, weight_read, zero pad
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int HW_N    = HIDDEN_UNITS * STATE_COUNT;
   localparam int HB_BASE = HW_N;
   localparam int OW_BASE = HW_N + HIDDEN_UNITS;
   localparam int OB_BASE = HW_N + 3 * HIDDEN_UNITS;
   localparam int DEPTH   = OB_BASE + 2;
   localparam int AW      = $clog2(DEPTH);
   localparam int UW      = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
   localparam int ACC_W   = RND_W + $clog2(HIDDEN_UNITS + 1) + 1;

   localparam logic [UW-1:0] U_LAST = UW'(HIDDEN_UNITS - 1);
   localparam logic [AW-1:0] A_LAST = AW'(DEPTH - 1);
   localparam logic [AW-1:0] A_SC   = AW'(STATE_COUNT);
   localparam logic [AW-1:0] A_HU   = AW'(HIDDEN_UNITS);
   localparam logic [AW-1:0] A_HB   = AW'(HB_BASE);
   localparam logic [AW-1:0] A_OW   = AW'(OW_BASE);
   localparam logic [AW-1:0] A_OB   = AW'(OB_BASE);

   localparam logic [4:0] ST_CLR   = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_F_HB  = 5'd2;
   localparam logic [4:0] ST_F_HW  = 5'd3;
   localparam logic [4:0] ST_F_O0  = 5'd4;
   localparam logic [4:0] ST_F_O1  = 5'd5;
   localparam logic [4:0] ST_F_A0  = 5'd6;
   localparam logic [4:0] ST_F_A1  = 5'd7;
   localparam logic [4:0] ST_F_OB0 = 5'd8;
   localparam logic [4:0] ST_F_OB1 = 5'd9;
   localparam logic [4:0] ST_F_FIN = 5'd10;
   localparam logic [4:0] ST_BEST  = 5'd11;
   localparam logic [4:0] ST_TGT   = 5'd12;
   localparam logic [4:0] ST_QLAT  = 5'd13;
   localparam logic [4:0] ST_ERR   = 5'd14;
   localparam logic [4:0] ST_GRAD  = 5'd15;
   localparam logic [4:0] ST_U_HB  = 5'd16;
   localparam logic [4:0] ST_U_HW  = 5'd17;
   localparam logic [4:0] ST_U_OW  = 5'd18;
   localparam logic [4:0] ST_U_M1  = 5'd19;
   localparam logic [4:0] ST_U_W1  = 5'd20;
   localparam logic [4:0] ST_U_M2  = 5'd21;
   localparam logic [4:0] ST_U_D   = 5'd22;
   localparam logic [4:0] ST_U_D2  = 5'd23;
   localparam logic [4:0] ST_U_OB  = 5'd24;
   localparam logic [4:0] ST_U_OBW = 5'd25;
   localparam logic [4:0] ST_SYNC  = 5'd26;
   localparam logic [4:0] ST_SYNCL = 5'd27;
   localparam logic [4:0] ST_WR    = 5'd28;
   localparam logic [4:0] ST_RD1   = 5'd29;
   localparam logic [4:0] ST_RD2   = 5'd30;
   localparam logic [4:0] ST_DONE  = 5'd31;

   logic [4:0]              state_ff, state_in;
   logic [UW-1:0]           u_ff, u_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [AW-1:0]           sw_ff, sw_in;
   logic                    net_ff, net_in;
   logic [2:0]              fst_ff, fst_in;
   logic [2:0]              act_ff, act_in;
   logic [2:0]              st_ff, st_in;
   logic                    mv_ff, mv_in;
   word_type                rew_ff, rew_in;
   logic [1:0]              kind_ff, kind_in;
   logic [3:0]              row_ff, row_in;
   logic [3:0]              col_ff, col_in;
   word_type                wval_ff, wval_in;
   word_type                b_ff, b_in;
   word_type                z_ff, z_in;
   word_type                hwv_ff, hwv_in;
   word_type                w_ff, w_in;
   logic signed [RND_W-1:0] delta_ff, delta_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc0_ff, acc0_in, acc1_ff, acc1_in;
   word_type                t_ff, t_in;
   word_type                g_ff, g_in;
   word_type                q0_ff, q0_in, q1_ff, q1_in;
   word_type                wr_ff, wr_in;
   logic [15:0]             lr_ff, lr_in;
   logic [16:0]             disc_ff, disc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   word_type                pol_rdata, frz_rdata, rdata;
   logic                    stv, slot_ok, z_pos, rsp_free, greedy;
   logic [AW-1:0]           hw_addr, slot_addr, rd_addr;
   logic [AW-1:0]           ow_mv_addr, ob_mv_addr;
   logic                    pol_we, frz_we;
   logic [AW-1:0]           pol_waddr, frz_waddr;
   word_type                pol_wdata, frz_wdata;
   logic signed [33:0]      mul_a;
   word_type                mul_b;
   logic                    mul_en;
   word_type                q0_sat, q1_sat, best, qm;
   logic signed [32:0]      dif;
   logic signed [33:0]      dvec;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rdata      = net_ff ? frz_rdata : pol_rdata;
   assign stv        = int'(fst_ff) < STATE_COUNT;
   assign hw_addr    = stv ? (base_ff + AW'(fst_ff)) : '0;
   assign ow_mv_addr = A_OW + (mv_ff ? A_HU : '0) + AW'(u_ff);
   assign ob_mv_addr = A_OB + AW'(mv_ff);
   assign z_pos      = z_ff > 32'sd0;
   assign q0_sat     = sat32(64'(acc0_ff));
   assign q1_sat     = sat32(64'(acc1_ff));
   assign best       = (q0_sat > q1_sat) ? q0_sat : q1_sat;
   assign qm         = mv_ff ? q1_ff : q0_ff;
   assign dif        = 33'(qm) - 33'(t_ff);
   assign dvec       = $signed({dif, 1'b0});
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign greedy     = q1_ff > q0_ff;

   always_comb begin
      slot_ok   = 1'b0;
      slot_addr = '0;
      case (kind_ff)
         KIND_HW: begin
            slot_ok   = (int'(row_ff) < HIDDEN_UNITS) && (int'(col_ff) < STATE_COUNT);
            slot_addr = AW'(int'(row_ff) * STATE_COUNT + int'(col_ff));
         end
         KIND_HB: begin
            slot_ok   = int'(row_ff) < HIDDEN_UNITS;
            slot_addr = AW'(HB_BASE + int'(row_ff));
         end
         KIND_OW: begin
            slot_ok   = (row_ff[3:1] == 3'd0) && (int'(col_ff) < HIDDEN_UNITS);
            slot_addr = AW'(OW_BASE + int'(row_ff[0]) * HIDDEN_UNITS + int'(col_ff));
         end
         default: begin
            slot_ok   = row_ff[3:1] == 3'd0;
            slot_addr = AW'(OB_BASE + int'(row_ff[0]));
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_F_HB:  rd_addr = A_HB + AW'(u_ff);
         ST_F_HW:  rd_addr = hw_addr;
         ST_F_O0:  rd_addr = A_OW + AW'(u_ff);
         ST_F_O1:  rd_addr = A_OW + A_HU + AW'(u_ff);
         ST_F_OB0: rd_addr = A_OB;
         ST_F_OB1: rd_addr = A_OB + AW'(1);
         ST_U_HB:  rd_addr = A_HB + AW'(u_ff);
         ST_U_HW:  rd_addr = hw_addr;
         ST_U_OW:  rd_addr = ow_mv_addr;
         ST_U_OB:  rd_addr = ob_mv_addr;
         ST_SYNC:  rd_addr = sw_ff;
         ST_RD1:   rd_addr = slot_addr;
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      base_in      = base_ff;
      sw_in        = sw_ff;
      net_in       = net_ff;
      fst_in       = fst_ff;
      act_in       = act_ff;
      st_in        = st_ff;
      mv_in        = mv_ff;
      rew_in       = rew_ff;
      kind_in      = kind_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wval_in      = wval_ff;
      b_in         = b_ff;
      z_in         = z_ff;
      hwv_in       = hwv_ff;
      w_in         = w_ff;
      delta_in     = delta_ff;
      acc0_in      = acc0_ff;
      acc1_in      = acc1_ff;
      t_in         = t_ff;
      g_in         = g_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      wr_in        = wr_ff;
      lr_in        = lr_ff;
      disc_in      = disc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pol_we       = 1'b0;
      pol_waddr    = '0;
      pol_wdata    = '0;
      frz_we       = 1'b0;
      frz_waddr    = '0;
      frz_wdata    = '0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      if (csr_valid) begin
         if (csr_index == CSR_LR) begin
            lr_in = csr_data[15:0];
         end else begin
            disc_in = csr_data;
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLR: begin
            pol_we    = 1'b1;
            pol_waddr = sw_ff;
            frz_we    = 1'b1;
            frz_waddr = sw_ff;
            sw_in     = sw_ff + AW'(1);
            if (sw_ff == A_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in  = req_tuser;
               st_in   = req_tdata[2:0];
               mv_in   = req_tdata[3];
               rew_in  = req_tdata[35:4];
               kind_in = req_tdata[41:40];
               row_in  = req_tdata[45:42];
               col_in  = req_tdata[49:46];
               wval_in = req_tdata[81:50];
               q0_in   = '0;
               q1_in   = '0;
               wr_in   = '0;
               net_in  = 1'b0;
               fst_in  = req_tdata[2:0];
               u_in    = '0;
               base_in = '0;
               acc0_in = '0;
               acc1_in = '0;
               sw_in   = '0;
               case (req_tuser)
                  ACT_INFER: state_in = ST_F_HB;
                  ACT_TRAIN: begin
                     state_in = ST_F_HB;
                     if (req_tdata[39]) begin
                        t_in = req_tdata[35:4];
                     end else begin
                        net_in = 1'b1;
                        fst_in = req_tdata[38:36];
                     end
                  end
                  ACT_SYNC:  state_in = ST_SYNC;
                  ACT_WRITE: state_in = ST_WR;
                  ACT_READ:  state_in = ST_RD1;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_F_HB: state_in = ST_F_HW;
         ST_F_HW: begin
            b_in     = rdata;
            state_in = ST_F_O0;
         end
         ST_F_O0: begin
            z_in     = sat32(64'(b_ff) + (stv ? 64'(rdata) : 64'sd0));
            state_in = ST_F_O1;
         end
         ST_F_O1: begin
            mul_en   = 1'b1;
            mul_a    = 34'(rdata);
            mul_b    = z_ff;
            state_in = ST_F_A0;
         end
         ST_F_A0: begin
            mul_en = 1'b1;
            mul_a  = 34'(rdata);
            mul_b  = z_ff;
            if (z_pos) begin
               acc0_in = acc0_ff + ACC_W'(rnd16(prod_ff));
            end
            state_in = ST_F_A1;
         end
         ST_F_A1: begin
            if (z_pos) begin
               acc1_in = acc1_ff + ACC_W'(rnd16(prod_ff));
            end
            u_in    = u_ff + UW'(1);
            base_in = base_ff + A_SC;
            state_in = (u_ff == U_LAST) ? ST_F_OB0 : ST_F_HB;
         end
         ST_F_OB0: state_in = ST_F_OB1;
         ST_F_OB1: begin
            acc0_in  = acc0_ff + ACC_W'(rdata);
            state_in = ST_F_FIN;
         end
         ST_F_FIN: begin
            acc1_in  = acc1_ff + ACC_W'(rdata);
            state_in = net_ff ? ST_BEST : ST_QLAT;
         end
         ST_BEST: begin
            mul_en   = 1'b1;
            mul_a    = 34'(best);
            mul_b    = $signed({15'd0, disc_ff});
            state_in = ST_TGT;
         end
         ST_TGT: begin
            t_in     = sat32(64'(rew_ff) + 64'(rnd16(prod_ff)));
            net_in   = 1'b0;
            fst_in   = st_ff;
            u_in     = '0;
            base_in  = '0;
            acc0_in  = '0;
            acc1_in  = '0;
            state_in = ST_F_HB;
         end
         ST_QLAT: begin
            q0_in    = q0_sat;
            q1_in    = q1_sat;
            state_in = (act_ff == ACT_TRAIN) ? ST_ERR : ST_DONE;
         end
         ST_ERR: begin
            mul_en   = 1'b1;
            mul_a    = dvec;
            mul_b    = $signed({16'd0, lr_ff});
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            g_in     = sat32(64'(rnd16(prod_ff)));
            u_in     = '0;
            base_in  = '0;
            state_in = ST_U_HB;
         end
         ST_U_HB: state_in = ST_U_HW;
         ST_U_HW: begin
            b_in     = rdata;
            state_in = ST_U_OW;
         end
         ST_U_OW: begin
            hwv_in   = rdata;
            z_in     = sat32(64'(b_ff) + (stv ? 64'(rdata) : 64'sd0));
            state_in = ST_U_M1;
         end
         ST_U_M1: begin
            w_in     = rdata;
            mul_en   = 1'b1;
            mul_a    = 34'(g_ff);
            mul_b    = z_ff;
            state_in = ST_U_W1;
         end
         ST_U_W1: begin
            w_in      = sat32(64'(w_ff) - 64'(rnd16(prod_ff)));
            pol_we    = z_pos;
            pol_waddr = ow_mv_addr;
            pol_wdata = w_in;
            state_in  = ST_U_M2;
         end
         ST_U_M2: begin
            mul_en   = 1'b1;
            mul_a    = 34'(g_ff);
            mul_b    = w_ff;
            state_in = ST_U_D;
         end
         ST_U_D: begin
            delta_in  = rnd16(prod_ff);
            pol_we    = z_pos;
            pol_waddr = A_HB + AW'(u_ff);
            pol_wdata = sat32(64'(b_ff) - 64'(rnd16(prod_ff)));
            state_in  = ST_U_D2;
         end
         ST_U_D2: begin
            pol_we    = z_pos && stv;
            pol_waddr = hw_addr;
            pol_wdata = sat32(64'(hwv_ff) - 64'(delta_ff));
            u_in      = u_ff + UW'(1);
            base_in   = base_ff + A_SC;
            state_in  = (u_ff == U_LAST) ? ST_U_OB : ST_U_HB;
         end
         ST_U_OB: state_in = ST_U_OBW;
         ST_U_OBW: begin
            pol_we    = 1'b1;
            pol_waddr = ob_mv_addr;
            pol_wdata = sat32(64'(rdata) - 64'(g_ff));
            state_in  = ST_DONE;
         end
         ST_SYNC: begin
            frz_we    = sw_ff != '0;
            frz_waddr = sw_ff - AW'(1);
            frz_wdata = pol_rdata;
            sw_in     = sw_ff + AW'(1);
            if (sw_ff == A_LAST) begin
               state_in = ST_SYNCL;
            end
         end
         ST_SYNCL: begin
            frz_we    = 1'b1;
            frz_waddr = A_LAST;
            frz_wdata = pol_rdata;
            state_in  = ST_DONE;
         end
         ST_WR: begin
            pol_we    = slot_ok;
            pol_waddr = slot_addr;
            pol_wdata = wval_ff;
            state_in  = ST_DONE;
         end
         ST_RD1: state_in = ST_RD2;
         ST_RD2: begin
            wr_in    = slot_ok ? rdata : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, wr_ff, greedy, q1_ff, q0_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign prod_in = mul_en ? (PROD_W'(mul_a) * PROD_W'(mul_b)) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         sw_ff        <= '0;
         lr_ff        <= LR_RESET;
         disc_ff      <= DISC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         lr_ff        <= lr_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      base_ff     <= base_in;
      net_ff      <= net_in;
      fst_ff      <= fst_in;
      act_ff      <= act_in;
      st_ff       <= st_in;
      mv_ff       <= mv_in;
      rew_ff      <= rew_in;
      kind_ff     <= kind_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      wval_ff     <= wval_in;
      b_ff        <= b_in;
      z_ff        <= z_in;
      hwv_ff      <= hwv_in;
      w_ff        <= w_in;
      delta_ff    <= delta_in;
      prod_ff     <= prod_in;
      acc0_ff     <= acc0_in;
      acc1_ff     <= acc1_in;
      t_ff        <= t_in;
      g_ff        <= g_in;
      q0_ff       <= q0_in;
      q1_ff       <= q1_in;
      wr_ff       <= wr_in;
      rsp_data_ff <= rsp_data_in;
   end

   qtd_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_pol_ram (
      .clock (clock),
      .we    (pol_we),
      .waddr (pol_waddr),
      .wdata (pol_wdata),
      .raddr (rd_addr),
      .rdata (pol_rdata)
   );

   qtd_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_frz_ram (
      .clock (clock),
      .we    (frz_we),
      .waddr (frz_waddr),
      .wdata (frz_wdata),
      .raddr (rd_addr),
      .rdata (frz_rdata)
   );

   `QTD_ASSERT(a_rsp_from_done, $rose(rsp_tvalid) |-> $past(state_ff) == ST_DONE, "rsp without done")
   `QTD_ASSERT(a_greedy, rsp_tvalid && rsp_tdata[64] |-> $signed(rsp_tdata[63:32]) > $signed(rsp_tdata[31:0]), "greedy")
   `QTD_ASSERT(a_pol_waddr, pol_we |-> pol_waddr <= A_LAST, "policy write out of range")
   `QTD_ASSERT(a_dual_write, pol_we && frz_we |-> state_ff == ST_CLR, "both RAMs written")

endmodule

`default_nettype wire
